FILE: rtl/core/enigma_pkg.sv
// ----------------------------------------------------------------------------
// Enigma package
// Shared types, wiring tables and modulo-26 helpers for the rotor cipher.
// ----------------------------------------------------------------------------
package enigma_pkg;

    localparam int unsigned NUM_SLOTS  = 3;
    localparam int unsigned NUM_WHEELS = 5;
    localparam int unsigned NUM_LETTERS = 26;

    typedef logic [4:0] letter_t;
    typedef logic [2:0] wheel_t;
    typedef logic [NUM_SLOTS-1:0][4:0] slot_letters_t;
    typedef wheel_t [NUM_SLOTS-1:0] slot_wheels_t;
    typedef logic [NUM_LETTERS-1:0][4:0] plug_map_t;

    // Configuration register indexes.
    typedef enum logic [2:0]
    {
        REG_ROTOR_SELECT    = 3'd0,
        REG_RING_SETTINGS   = 3'd1,
        REG_START_POSITIONS = 3'd2,
        REG_PLUG_LOW        = 3'd3,
        REG_PLUG_MID        = 3'd4,
        REG_PLUG_HIGH       = 3'd5
    } cfg_reg_t;

    // Slot 0 is the right rotor, slot 2 the left one.
    localparam int unsigned SLOT_RIGHT  = 0;
    localparam int unsigned SLOT_MIDDLE = 1;
    localparam int unsigned SLOT_LEFT   = 2;

    // Letter i of each string sits at byte NUM_LETTERS-1-i.
    localparam logic [NUM_LETTERS-1:0][7:0] REFLECTOR_CHARS = "YRUHQSLDPXNGOKMIEBFZCWVJAT";
    localparam logic [NUM_WHEELS-1:0][NUM_LETTERS-1:0][7:0] WHEEL_CHARS = {
        "VZBRGITYUPSDNHLXAWMJQOFECK",
        "ESOVPZJAYQUIRHXLNFTGKDCMWB",
        "BDFHJLCPRTXVZNYEIWGAKMUSQO",
        "AJDKSIRUXBLHWTMCQGZNPYFVOE",
        "EKMFLGDQVZNTOWYHXUSPAIBRCJ"
    };
    localparam logic [NUM_WHEELS-1:0][4:0] NOTCH_POS = {5'd25, 5'd9, 5'd21, 5'd4, 5'd16};
    localparam logic [7:0] CHAR_A = 8'd65;

    typedef struct packed {
        letter_t letter;
        logic    is_space;
    } plain_word_t;

    typedef struct packed {
        letter_t cipher_letter;
        logic    out_space;
    } cipher_word_t;

    // One classified letter on its way to the substitution pipeline.
    typedef struct packed {
        logic          is_space;
        letter_t       letter;
        slot_letters_t shift;
    } item_t;

    typedef struct packed {
        logic          load;
        slot_letters_t start;
        slot_letters_t ring;
        slot_wheels_t  wheel;
    } front_cfg_t;

    function automatic letter_t mod26(input logic [4:0] v);
        letter_t r;
        r = (v >= 5'd26) ? v - 5'd26 : v;
        return r;
    endfunction

    function automatic letter_t add26(input letter_t a, input letter_t b);
        logic [5:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 6'd26)
        begin
            s = s - 6'd26;
        end
        return s[4:0];
    endfunction

    function automatic letter_t sub26(input letter_t a, input letter_t b);
        logic [5:0] d;
        d = {1'b0, a} + 6'd26 - {1'b0, b};
        if (d >= 6'd26)
        begin
            d = d - 6'd26;
        end
        return d[4:0];
    endfunction

    function automatic wheel_t wheel_reduce(input logic [2:0] code);
        wheel_t w;
        w = (code >= 3'd5) ? code - 3'd5 : code;
        return w;
    endfunction

    function automatic letter_t wheel_fwd(input wheel_t w, input letter_t i);
        logic [7:0] ch;
        ch = WHEEL_CHARS[w][5'd25 - i] - CHAR_A;
        return ch[4:0];
    endfunction

    // Inverse wiring: compare every contact against the wanted output.
    function automatic letter_t wheel_bwd(input wheel_t w, input letter_t t);
        letter_t k;
        k = '0;
        for (int unsigned i = 0; i < NUM_LETTERS; i++)
        begin
            if (wheel_fwd(w, letter_t'(i)) == t)
            begin
                k = letter_t'(i);
            end
        end
        return k;
    endfunction

    function automatic letter_t reflect(input letter_t c);
        logic [7:0] ch;
        ch = REFLECTOR_CHARS[5'd25 - c] - CHAR_A;
        return ch[4:0];
    endfunction

    function automatic letter_t notch_of(input wheel_t w);
        return NOTCH_POS[w];
    endfunction

endpackage

FILE: rtl/core/enigma_front.sv
// ----------------------------------------------------------------------------
// Enigma front end
// Accepts words, steps the rotor positions and queues each word together
// with the rotor offsets it must be enciphered under.
// ----------------------------------------------------------------------------
module enigma_front
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     plain_valid,
    output logic                     plain_ready,
    input  enigma_pkg::plain_word_t  plain_word,
    input  enigma_pkg::front_cfg_t   cfg,
    input  logic                     q_full,
    output logic                     q_push,
    output enigma_pkg::item_t        q_item
);

    enigma_pkg::slot_letters_t pos_reg;
    enigma_pkg::slot_letters_t pos_next;
    enigma_pkg::slot_letters_t stepped;
    logic                      right_notch;
    logic                      middle_notch;
    logic                      accept;

    assign plain_ready = !q_full;
    assign accept      = plain_valid && plain_ready;
    assign q_push      = accept;

    always_comb
    begin
        right_notch  = pos_reg[enigma_pkg::SLOT_RIGHT] ==
                       enigma_pkg::notch_of(cfg.wheel[enigma_pkg::SLOT_RIGHT]);
        middle_notch = pos_reg[enigma_pkg::SLOT_MIDDLE] ==
                       enigma_pkg::notch_of(cfg.wheel[enigma_pkg::SLOT_MIDDLE]);

        // A middle rotor at its notch carries the left one and steps itself
        // again, which gives the double step.
        stepped = pos_reg;
        stepped[enigma_pkg::SLOT_RIGHT] = enigma_pkg::add26(pos_reg[enigma_pkg::SLOT_RIGHT], 5'd1);
        if (right_notch || middle_notch)
        begin
            stepped[enigma_pkg::SLOT_MIDDLE] =
                enigma_pkg::add26(pos_reg[enigma_pkg::SLOT_MIDDLE], 5'd1);
        end
        if (middle_notch)
        begin
            stepped[enigma_pkg::SLOT_LEFT] =
                enigma_pkg::add26(pos_reg[enigma_pkg::SLOT_LEFT], 5'd1);
        end

        pos_next = pos_reg;
        if (cfg.load)
        begin
            for (int unsigned k = 0; k < enigma_pkg::NUM_SLOTS; k++)
            begin
                pos_next[k] = enigma_pkg::mod26(cfg.start[k]);
            end
        end
        else if (accept && !plain_word.is_space)
        begin
            pos_next = stepped;
        end

        q_item.is_space = plain_word.is_space;
        q_item.letter   = plain_word.is_space ? 5'd0 : enigma_pkg::mod26(plain_word.letter);
        for (int unsigned k = 0; k < enigma_pkg::NUM_SLOTS; k++)
        begin
            q_item.shift[k] = enigma_pkg::sub26(stepped[k], enigma_pkg::mod26(cfg.ring[k]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

FILE: rtl/core/enigma_queue.sv
// ----------------------------------------------------------------------------
// Enigma item queue
// Two-entry queue that decouples the stepping front end from the
// substitution pipeline.
// ----------------------------------------------------------------------------
module enigma_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  enigma_pkg::item_t  push_item,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output enigma_pkg::item_t  head
);

    enigma_pkg::item_t entry_reg [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/core/enigma_back.sv
// ----------------------------------------------------------------------------
// Enigma substitution pipeline
// Nine steps carry a letter through plugboard, rotors, reflector, rotors
// in reverse and plugboard again; the last register is the output register.
// ----------------------------------------------------------------------------
module enigma_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  enigma_pkg::item_t          q_head,
    output logic                       q_pop,
    input  enigma_pkg::slot_wheels_t   wheel,
    input  enigma_pkg::plug_map_t      plug_raw,
    output logic                       cipher_valid,
    input  logic                       cipher_ready,
    output enigma_pkg::cipher_word_t   cipher_word
);

    localparam int unsigned NUM_OPS = 9;

    enigma_pkg::item_t    stage_reg  [NUM_OPS+1];
    enigma_pkg::item_t    stage_next [NUM_OPS];
    logic [NUM_OPS:0]     valid_reg;
    logic                 advance;

    function automatic enigma_pkg::letter_t plug_map(input enigma_pkg::plug_map_t map,
                                                     input enigma_pkg::letter_t c);
        return enigma_pkg::add26(c, enigma_pkg::mod26(map[c]));
    endfunction

    function automatic enigma_pkg::letter_t rotor_fwd(input enigma_pkg::wheel_t w,
                                                      input enigma_pkg::letter_t s,
                                                      input enigma_pkg::letter_t c);
        return enigma_pkg::sub26(enigma_pkg::wheel_fwd(w, enigma_pkg::add26(c, s)), s);
    endfunction

    function automatic enigma_pkg::letter_t rotor_bwd(input enigma_pkg::wheel_t w,
                                                      input enigma_pkg::letter_t s,
                                                      input enigma_pkg::letter_t c);
        return enigma_pkg::sub26(enigma_pkg::wheel_bwd(w, enigma_pkg::add26(c, s)), s);
    endfunction

    // The whole pipeline moves together; it holds only while the output
    // register carries a word the receiver has not taken.
    assign advance = !valid_reg[NUM_OPS] || cipher_ready;
    assign q_pop   = advance && q_valid;

    always_comb
    begin
        for (int unsigned k = 0; k < NUM_OPS; k++)
        begin
            stage_next[k] = stage_reg[k];
        end
        stage_next[0].letter = plug_map(plug_raw, stage_reg[0].letter);
        stage_next[1].letter = rotor_fwd(wheel[enigma_pkg::SLOT_RIGHT],
                                         stage_reg[1].shift[enigma_pkg::SLOT_RIGHT],
                                         stage_reg[1].letter);
        stage_next[2].letter = rotor_fwd(wheel[enigma_pkg::SLOT_MIDDLE],
                                         stage_reg[2].shift[enigma_pkg::SLOT_MIDDLE],
                                         stage_reg[2].letter);
        stage_next[3].letter = rotor_fwd(wheel[enigma_pkg::SLOT_LEFT],
                                         stage_reg[3].shift[enigma_pkg::SLOT_LEFT],
                                         stage_reg[3].letter);
        stage_next[4].letter = enigma_pkg::reflect(stage_reg[4].letter);
        stage_next[5].letter = rotor_bwd(wheel[enigma_pkg::SLOT_LEFT],
                                         stage_reg[5].shift[enigma_pkg::SLOT_LEFT],
                                         stage_reg[5].letter);
        stage_next[6].letter = rotor_bwd(wheel[enigma_pkg::SLOT_MIDDLE],
                                         stage_reg[6].shift[enigma_pkg::SLOT_MIDDLE],
                                         stage_reg[6].letter);
        stage_next[7].letter = rotor_bwd(wheel[enigma_pkg::SLOT_RIGHT],
                                         stage_reg[7].shift[enigma_pkg::SLOT_RIGHT],
                                         stage_reg[7].letter);
        stage_next[8].letter = plug_map(plug_raw, stage_reg[8].letter);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[NUM_OPS-1:0], q_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg[0] <= q_head;
            for (int unsigned k = 0; k < NUM_OPS; k++)
            begin
                stage_reg[k+1] <= stage_next[k];
            end
        end
    end

    assign cipher_valid              = valid_reg[NUM_OPS];
    assign cipher_word.out_space     = stage_reg[NUM_OPS].is_space;
    assign cipher_word.cipher_letter = stage_reg[NUM_OPS].is_space ? 5'd0
                                                                   : stage_reg[NUM_OPS].letter;

endmodule

FILE: rtl/core/three_rotor_enigma_cipher.sv
// ----------------------------------------------------------------------------
// Three-rotor Enigma cipher
// Configuration registers, rotor stepping front end, item queue and the
// substitution pipeline.
// ----------------------------------------------------------------------------
// Usage:
// Plain words (a letter or a space) enter on plain_valid/plain_ready and
// enciphered words leave on cipher_valid/cipher_ready, one word out for each
// word in, in order. A letter steps the rotors before it is enciphered; a
// space steps nothing and comes out as a space with letter zero.
// Throughput is one word per cycle while the receiver does not stall. An
// accepted word passes through the two-entry queue and then the pipeline
// stages, the last of which is the output register.
// When the receiver stalls, the pipeline holds, the queue fills and
// plain_ready falls once the queue holds two words.
// Reset clears the pipeline and queue, sets the rotor choice to I, II, III
// (left to right), rings, positions and plugboard to zero.
// Configuration is written with cfg_we, cfg_index and cfg_data while no
// words are in flight; writing the start positions reloads the rotors.
// ----------------------------------------------------------------------------
module three_rotor_enigma_cipher
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      plain_valid,
    output logic                      plain_ready,
    input  enigma_pkg::plain_word_t   plain_word,
    output logic                      cipher_valid,
    input  logic                      cipher_ready,
    output enigma_pkg::cipher_word_t  cipher_word,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_index,
    input  logic [59:0]               cfg_data
);

    logic [8:0]                rotor_select_reg;
    logic [14:0]               ring_settings_reg;
    logic [14:0]               start_positions_reg;
    logic [59:0]               plug_low_reg;
    logic [59:0]               plug_mid_reg;
    logic [9:0]                plug_high_reg;
    enigma_pkg::slot_wheels_t  wheel_sel;
    enigma_pkg::front_cfg_t    front_cfg;
    enigma_pkg::plug_map_t     plug_raw;
    enigma_pkg::item_t         push_item;
    enigma_pkg::item_t         head_item;
    logic                      q_push;
    logic                      q_full;
    logic                      q_pop;
    logic                      q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotor_select_reg    <= 9'd10;
            ring_settings_reg   <= '0;
            start_positions_reg <= '0;
            plug_low_reg        <= '0;
            plug_mid_reg        <= '0;
            plug_high_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (enigma_pkg::cfg_reg_t'(cfg_index))
                enigma_pkg::REG_ROTOR_SELECT:    rotor_select_reg    <= cfg_data[8:0];
                enigma_pkg::REG_RING_SETTINGS:   ring_settings_reg   <= cfg_data[14:0];
                enigma_pkg::REG_START_POSITIONS: start_positions_reg <= cfg_data[14:0];
                enigma_pkg::REG_PLUG_LOW:        plug_low_reg        <= cfg_data;
                enigma_pkg::REG_PLUG_MID:        plug_mid_reg        <= cfg_data;
                enigma_pkg::REG_PLUG_HIGH:       plug_high_reg       <= cfg_data[9:0];
                default:                         ;
            endcase
        end
    end

    always_comb
    begin
        for (int unsigned k = 0; k < enigma_pkg::NUM_SLOTS; k++)
        begin
            wheel_sel[k] = enigma_pkg::wheel_reduce(rotor_select_reg[3*k +: 3]);
        end
        front_cfg.load  = cfg_we &&
                          (enigma_pkg::cfg_reg_t'(cfg_index) == enigma_pkg::REG_START_POSITIONS);
        front_cfg.start = cfg_data[14:0];
        front_cfg.ring  = ring_settings_reg;
        front_cfg.wheel = wheel_sel;
        plug_raw        = {plug_high_reg, plug_mid_reg, plug_low_reg};
    end

    enigma_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .plain_valid (plain_valid),
        .plain_ready (plain_ready),
        .plain_word  (plain_word),
        .cfg         (front_cfg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    enigma_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (head_item)
    );

    enigma_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (head_item),
        .q_pop        (q_pop),
        .wheel        (wheel_sel),
        .plug_raw     (plug_raw),
        .cipher_valid (cipher_valid),
        .cipher_ready (cipher_ready),
        .cipher_word  (cipher_word)
    );

endmodule

FILE: rtl/core/enigma_checker.sv
// ----------------------------------------------------------------------------
// Enigma port checker
// Watches the ports of the cipher block and flags broken input and output behaviour.
// ----------------------------------------------------------------------------
module enigma_checker
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      plain_valid,
    input  logic                      plain_ready,
    input  enigma_pkg::plain_word_t   plain_word,
    input  logic                      cipher_valid,
    input  logic                      cipher_ready,
    input  enigma_pkg::cipher_word_t  cipher_word
);

    // A waiting input word must stay offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        plain_valid && !plain_ready |=> plain_valid && $stable(plain_word))
        else $error("input word withdrawn or changed while waiting");

    // A stalled output word must stay offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        cipher_valid && !cipher_ready |=> cipher_valid)
        else $error("output word dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        cipher_valid && !cipher_ready |=> $stable(cipher_word))
        else $error("output word changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        cipher_valid && cipher_word.out_space |-> cipher_word.cipher_letter == 5'd0)
        else $error("space carries a non-zero letter");

    // Every enciphered letter lies in the alphabet.
    assert property (@(posedge clk) disable iff (!rst_n)
        cipher_valid && !cipher_word.out_space |-> cipher_word.cipher_letter < 5'd26)
        else $error("enciphered letter out of range");

endmodule

bind three_rotor_enigma_cipher enigma_checker u_enigma_checker (.*);

FILE: bench/tb_three_rotor_enigma_cipher.sv
// ----------------------------------------------------------------------------
// Three-rotor Enigma cipher testbench
// Sends letter and space words through the cipher under several rotor, ring,
// position and plugboard settings and with random sender gaps and receiver
// stalls. A shadow of the rotor machine predicts every cipher word, and each
// word that leaves the block is checked in order against that prediction.
// ----------------------------------------------------------------------------
module tb_three_rotor_enigma_cipher;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned BLOCK_WORDS  = 56;

    // Shadow rotor machine: holds its own settings and positions and keeps
    // the cipher words that the block still owes.
    class rotor_shadow;
        logic [8:0]   rotor_sel;
        logic [14:0]  rings;
        logic [14:0]  starts;
        logic [129:0] plugs;
        int unsigned  pos [3];
        string        wiring [5];
        string        reflector;
        int unsigned  notch [5];
        enigma_pkg::cipher_word_t expected_cipher [$];
        int unsigned  errors;
        int unsigned  letters;
        int unsigned  spaces;
        int unsigned  turnovers;
        int unsigned  double_steps;

        function new();
            wiring[0] = "EKMFLGDQVZNTOWYHXUSPAIBRCJ";
            wiring[1] = "AJDKSIRUXBLHWTMCQGZNPYFVOE";
            wiring[2] = "BDFHJLCPRTXVZNYEIWGAKMUSQO";
            wiring[3] = "ESOVPZJAYQUIRHXLNFTGKDCMWB";
            wiring[4] = "VZBRGITYUPSDNHLXAWMJQOFECK";
            reflector = "YRUHQSLDPXNGOKMIEBFZCWVJAT";
            notch[0] = 16;
            notch[1] = 4;
            notch[2] = 21;
            notch[3] = 9;
            notch[4] = 25;
            rotor_sel = 9'd10;
            rings = '0;
            starts = '0;
            plugs = '0;
            pos[0] = 0;
            pos[1] = 0;
            pos[2] = 0;
            errors = 0;
            letters = 0;
            spaces = 0;
            turnovers = 0;
            double_steps = 0;
        endfunction

        function int unsigned field_of(logic [129:0] v, int unsigned slot);
            logic [4:0] f;
            f = v[5*slot +: 5];
            return f % 26;
        endfunction

        function int unsigned wheel_in(int unsigned slot);
            logic [2:0] code;
            code = rotor_sel[3*slot +: 3];
            return code % 5;
        endfunction

        function int unsigned plug_of(int unsigned c);
            return (c + field_of(plugs, c)) % 26;
        endfunction

        // One pass through the rotor in a slot, towards the reflector or back.
        function int unsigned through(int unsigned slot, int unsigned c, bit back);
            int unsigned shift;
            int unsigned w;
            int unsigned t;
            int unsigned k;
            shift = (pos[slot] + 26 - field_of({115'd0, rings}, slot)) % 26;
            w = wheel_in(slot);
            t = (c + shift) % 26;
            if (!back)
            begin
                k = int'(wiring[w][t]) - 65;
            end
            else
            begin
                k = 0;
                for (int unsigned i = 0; i < 26; i++)
                begin
                    if (int'(wiring[w][i]) - 65 == t)
                    begin
                        k = i;
                    end
                end
            end
            return (k + 26 - shift) % 26;
        endfunction

        function void set_reg(enigma_pkg::cfg_reg_t idx, logic [59:0] v);
            case (idx)
                enigma_pkg::REG_ROTOR_SELECT:    rotor_sel = v[8:0];
                enigma_pkg::REG_RING_SETTINGS:   rings = v[14:0];
                enigma_pkg::REG_START_POSITIONS:
                begin
                    starts = v[14:0];
                    for (int unsigned s = 0; s < 3; s++)
                    begin
                        pos[s] = field_of({115'd0, starts}, s);
                    end
                end
                enigma_pkg::REG_PLUG_LOW:        plugs[59:0] = v;
                enigma_pkg::REG_PLUG_MID:        plugs[119:60] = v;
                enigma_pkg::REG_PLUG_HIGH:       plugs[129:120] = v[9:0];
                default:                         ;
            endcase
        endfunction

        function void accept_plain(enigma_pkg::plain_word_t w);
            enigma_pkg::cipher_word_t e;
            int unsigned  c;
            bit           right_at_notch;
            bit           middle_at_notch;
            int           s;
            if (w.is_space)
            begin
                e.cipher_letter = '0;
                e.out_space = 1'b1;
                spaces++;
            end
            else
            begin
                right_at_notch = (pos[0] == notch[wheel_in(0)]);
                middle_at_notch = (pos[1] == notch[wheel_in(1)]);
                if (middle_at_notch)
                begin
                    pos[2] = (pos[2] + 1) % 26;
                    double_steps++;
                end
                if (middle_at_notch || right_at_notch)
                begin
                    pos[1] = (pos[1] + 1) % 26;
                    turnovers++;
                end
                pos[0] = (pos[0] + 1) % 26;
                c = plug_of(w.letter % 26);
                for (s = 0; s < 3; s++)
                begin
                    c = through(s, c, 1'b0);
                end
                c = int'(reflector[c]) - 65;
                for (s = 2; s >= 0; s--)
                begin
                    c = through(s, c, 1'b1);
                end
                c = plug_of(c);
                e.cipher_letter = c[4:0];
                e.out_space = 1'b0;
                letters++;
            end
            expected_cipher.push_back(e);
        endfunction

        function void check_cipher(enigma_pkg::cipher_word_t got);
            enigma_pkg::cipher_word_t e;
            if (expected_cipher.size() == 0)
            begin
                $display("%0t: unexpected cipher word, letter %0d space %0b", $time,
                         got.cipher_letter, got.out_space);
                errors++;
                return;
            end
            e = expected_cipher.pop_front();
            if (got.cipher_letter !== e.cipher_letter)
            begin
                $display("%0t: cipher_letter expected %0d, got %0d", $time,
                         e.cipher_letter, got.cipher_letter);
                errors++;
            end
            if (got.out_space !== e.out_space)
            begin
                $display("%0t: out_space expected %0b, got %0b", $time,
                         e.out_space, got.out_space);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_cipher.size();
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     plain_valid = 1'b0;
    logic                     plain_ready;
    enigma_pkg::plain_word_t  plain_word = '0;
    logic                     cipher_valid;
    logic                     cipher_ready = 1'b0;
    enigma_pkg::cipher_word_t cipher_word;
    logic                     cfg_we = 1'b0;
    enigma_pkg::cfg_reg_t     cfg_index = enigma_pkg::REG_ROTOR_SELECT;
    logic [59:0]              cfg_data = '0;

    rotor_shadow  shadow = new();
    int unsigned  send_idle_pct = 0;
    int unsigned  stall_pct = 0;
    int unsigned  cycle_count = 0;
    int unsigned  settings_used = 1;

    three_rotor_enigma_cipher dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .plain_valid  (plain_valid),
        .plain_ready  (plain_ready),
        .plain_word   (plain_word),
        .cipher_valid (cipher_valid),
        .cipher_ready (cipher_ready),
        .cipher_word  (cipher_word),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d words outstanding.",
                     cycle_count, shadow.pending());
            $display("three_rotor_enigma_cipher verification failed");
            $finish;
        end
    end

    // Handshakes are sampled with the values held before this edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (plain_valid && plain_ready)
            begin
                shadow.accept_plain(plain_word);
            end
            if (cipher_valid && cipher_ready)
            begin
                shadow.check_cipher(cipher_word);
            end
        end
        cipher_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic write_reg(input enigma_pkg::cfg_reg_t idx, input logic [59:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        shadow.set_reg(idx, v);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic push_plain(input logic [4:0] letter, input logic space);
        enigma_pkg::plain_word_t w;
        w.letter = letter;
        w.is_space = space;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            plain_valid <= 1'b0;
            @(posedge clk);
        end
        plain_valid <= 1'b1;
        plain_word <= w;
        @(posedge clk);
        while (!plain_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain();
        plain_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (shadow.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Style 0 clears everything, style 1 sets every bit, other styles pick a
    // random setting with the rotors often parked near their notches.
    task automatic load_setting(input int unsigned style);
        logic [129:0] offs;
        logic [8:0]   sel;
        logic [14:0]  ring;
        logic [14:0]  start;
        logic [4:0]   right_start;
        logic [4:0]   middle_start;
        bit   [25:0]  used;
        int unsigned  a;
        int unsigned  b;
        int unsigned  pairs;
        if (style == 0)
        begin
            sel = '0;
            ring = '0;
            start = '0;
            offs = '0;
        end
        else if (style == 1)
        begin
            sel = '1;
            ring = '1;
            start = '1;
            offs = '1;
        end
        else
        begin
            sel = 9'($urandom);
            ring = 15'($urandom);
            right_start = 5'($urandom_range(0, 31));
            middle_start = 5'($urandom_range(0, 31));
            if ($urandom_range(0, 1) == 1)
            begin
                right_start = 5'(shadow.notch[sel[2:0] % 5] - $urandom_range(0, 3));
                middle_start = 5'(shadow.notch[sel[5:3] % 5] - $urandom_range(0, 1));
            end
            start = {5'($urandom_range(0, 31)), middle_start, right_start};
            if ($urandom_range(0, 3) == 0)
            begin
                offs = 130'({$urandom, $urandom, $urandom, $urandom, $urandom});
            end
            else
            begin
                // A proper plugboard: pairs of letters swapped both ways.
                offs = '0;
                used = '0;
                pairs = $urandom_range(0, 13);
                for (int unsigned i = 0; i < pairs; i++)
                begin
                    a = $urandom_range(0, 25);
                    b = $urandom_range(0, 25);
                    if (a != b && !used[a] && !used[b])
                    begin
                        offs[5*a +: 5] = 5'((b + 26 - a) % 26);
                        offs[5*b +: 5] = 5'((a + 26 - b) % 26);
                        used[a] = 1'b1;
                        used[b] = 1'b1;
                    end
                end
                for (int unsigned i = 0; i < 26; i++)
                begin
                    if (offs[5*i +: 5] < 5'd6 && $urandom_range(0, 7) == 0)
                    begin
                        offs[5*i +: 5] = offs[5*i +: 5] + 5'd26;
                    end
                end
            end
        end
        write_reg(enigma_pkg::REG_ROTOR_SELECT, {51'd0, sel});
        write_reg(enigma_pkg::REG_RING_SETTINGS, {45'd0, ring});
        write_reg(enigma_pkg::REG_START_POSITIONS, {45'd0, start});
        write_reg(enigma_pkg::REG_PLUG_LOW, offs[59:0]);
        write_reg(enigma_pkg::REG_PLUG_MID, offs[119:60]);
        write_reg(enigma_pkg::REG_PLUG_HIGH, {50'd0, offs[129:120]});
        settings_used++;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: letter extremes, letters above Z and spaces.
        push_plain(5'd0, 1'b0);
        push_plain(5'd25, 1'b0);
        push_plain(5'd31, 1'b0);
        push_plain(5'd26, 1'b0);
        push_plain(5'd0, 1'b1);
        push_plain(5'd31, 1'b1);
        push_plain(5'd13, 1'b0);
        drain();

        // Right rotor on its notch and middle rotor on its own notch together.
        write_reg(enigma_pkg::REG_START_POSITIONS, {45'd0, 5'd0, 5'd4, 5'd21});
        for (int unsigned i = 0; i < 4; i++)
        begin
            push_plain(5'(i), 1'b0);
        end
        drain();

        // Rotor codes above four, fields above 25 and a one-way plug map.
        write_reg(enigma_pkg::REG_ROTOR_SELECT, {51'd0, 3'd7, 3'd6, 3'd5});
        write_reg(enigma_pkg::REG_RING_SETTINGS, {45'd0, 5'd31, 5'd27, 5'd26});
        write_reg(enigma_pkg::REG_START_POSITIONS, {45'd0, 5'd30, 5'd29, 5'd31});
        write_reg(enigma_pkg::REG_PLUG_LOW, '1);
        write_reg(enigma_pkg::REG_PLUG_MID, 60'h0123456789ABCDE);
        write_reg(enigma_pkg::REG_PLUG_HIGH, {50'd0, 10'h3FF});
        for (int unsigned i = 0; i < 5; i++)
        begin
            push_plain(5'(i * 6), 1'b0);
        end
        drain();

        // The same wheel in every slot, double stepping from its notch.
        write_reg(enigma_pkg::REG_ROTOR_SELECT, {51'd0, 3'd4, 3'd4, 3'd4});
        write_reg(enigma_pkg::REG_RING_SETTINGS, '0);
        write_reg(enigma_pkg::REG_START_POSITIONS, {45'd0, 5'd3, 5'd25, 5'd25});
        write_reg(enigma_pkg::REG_PLUG_LOW, '0);
        write_reg(enigma_pkg::REG_PLUG_MID, '0);
        write_reg(enigma_pkg::REG_PLUG_HIGH, '0);
        push_plain(5'd7, 1'b0);
        push_plain(5'd8, 1'b0);
        push_plain(5'd9, 1'b1);
        push_plain(5'd10, 1'b0);
        push_plain(5'd11, 1'b0);
        drain();

        for (int unsigned blk = 0; blk < 8; blk++)
        begin
            case (blk / 2)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 86; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 86; end
                default: begin send_idle_pct = 18; stall_pct = 18; end
            endcase
            load_setting(blk);
            for (int unsigned n = 0; n < BLOCK_WORDS; n++)
            begin
                if ($urandom_range(0, 99) < 12)
                begin
                    push_plain(5'($urandom_range(0, 31)), 1'b1);
                end
                else if ($urandom_range(0, 99) < 8)
                begin
                    push_plain(5'($urandom_range(26, 31)), 1'b0);
                end
                else
                begin
                    push_plain(5'($urandom_range(0, 25)), 1'b0);
                end
            end
            drain();
        end

        $display("Checked %0d letters and %0d spaces across %0d rotor settings.",
                 shadow.letters, shadow.spaces, settings_used);
        $display("Middle rotor turned over %0d times, %0d of them double steps.",
                 shadow.turnovers, shadow.double_steps);
        if (shadow.errors == 0)
        begin
            $display("three_rotor_enigma_cipher verification clean");
        end
        else
        begin
            $display("three_rotor_enigma_cipher verification failed");
        end
        $finish;
    end

endmodule
